FILE: src/cre_pkg.sv
package cre_pkg;

  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 16;
  localparam int MAX_WRITES = 3;

  // Largest ring the position field can address.
  localparam int POS_LIMIT = 1024;

  localparam logic [7:0]       CODE_MAX = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  // One byte write to the ring.
  typedef struct packed {
    logic [POS_W-1:0] addr;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } entry_t;

  // Encoder state carried from one item to the next.
  typedef struct packed {
    logic [POS_W-1:0] code_slot;
    logic [POS_W-1:0] write_pos;
    logic [7:0]       run_code;
    logic [CNT_W-1:0] frame_count;
  } enc_state_t;

  // All writes caused by one item, in order, entry 0 first.
  typedef struct packed {
    logic [1:0]             n;
    entry_t [MAX_WRITES-1:0] ent;
  } writes_t;

endpackage

FILE: src/cobs_ring_encoder_top.sv
// COBS ring encoder. Requests arrive on the input channel (in_valid, in_stall,
// req_type, data_byte, start_position): begin a frame, a data byte, or finish
// the frame. Each request produces one to three ring byte writes on the output
// channel (out_valid, out_stall, write_address, write_data, bytes_written,
// last); last marks the final write of a request. A beat moves when valid is
// high and stall is low. Code bytes are back-patched, so addresses are not
// monotonic within a frame.
// Order: an accepted request is held in the input register and moves into the
// burst register once that register is free, and its first write is then
// shown from the burst register. Throughput: one request per cycle for
// requests with a single write (plain data bytes) while the receiver does not
// stall; a request with two or three writes occupies the burst register for
// that many output beats, because the output port carries one write per beat.
// The ring size register (cfg_we, cfg_wdata) is clamped on write to the range
// 1..min(RING_DEPTH, 1024); the user must write it only while the block is
// idle, and the block itself does not enforce this.
// Reset (rst, synchronous) empties both registers, sets the ring size to its
// maximum and clears the encoder state (run code back to one). When the
// receiver stalls, the burst register holds, the input register fills, and
// then in_stall rises until writes drain.
module cobs_ring_encoder_top #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cre_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    data_byte,
  input  logic [cre_pkg::POS_W-1:0]     start_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cre_pkg::POS_W-1:0]     write_address,
  output logic [7:0]                    write_data,
  output logic [cre_pkg::CNT_W-1:0]     bytes_written,
  output logic                          last
);

  localparam logic [cre_pkg::SIZE_W-1:0] SizeLim =
    cre_pkg::SIZE_W'((RING_DEPTH > cre_pkg::POS_LIMIT) ? cre_pkg::POS_LIMIT : RING_DEPTH);

  // Ring size as used, clamped when written.
  logic [cre_pkg::SIZE_W-1:0] size_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_use <= SizeLim;
    end else if (cfg_we) begin
      if (cfg_wdata > SizeLim) begin
        size_use <= SizeLim;
      end else if (cfg_wdata == '0) begin
        size_use <= cre_pkg::SIZE_W'(1);
      end else begin
        size_use <= cfg_wdata;
      end
    end
  end

  // Input register.
  logic                      s1_valid;
  logic [1:0]                s1_req;
  logic [7:0]                s1_byte;
  logic [cre_pkg::POS_W-1:0] s1_start;

  // Burst register: pending writes of one request, entry 0 shown first.
  logic [1:0]                                 burst_rem;
  cre_pkg::entry_t [cre_pkg::MAX_WRITES-1:0] burst;

  cre_pkg::enc_state_t state;
  cre_pkg::enc_state_t state_next;
  cre_pkg::writes_t    writes;

  logic in_take;
  logic out_take;
  logic s1_move;

  assign out_valid = (burst_rem != 2'd0);
  assign out_take  = out_valid && !out_stall;
  // The burst register can take new writes when it is empty or its final
  // write leaves in this cycle.
  assign s1_move   = s1_valid && ((burst_rem == 2'd0) || (burst_rem == 2'd1 && out_take));
  assign in_stall  = s1_valid && !s1_move;
  assign in_take   = in_valid && !in_stall;

  assign write_address = burst[0].addr;
  assign write_data    = burst[0].data;
  assign bytes_written = burst[0].count;
  assign last          = (burst_rem == 2'd1);

  cre_step u_step (
    .req            (s1_req),
    .data_byte      (s1_byte),
    .start_position (s1_start),
    .size_use       (size_use),
    .cur            (state),
    .nxt            (state_next),
    .res            (writes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req   <= req_type;
      s1_byte  <= data_byte;
      s1_start <= start_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{code_slot: '0, write_pos: '0, run_code: 8'd1, frame_count: '0};
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_rem <= 2'd0;
    end else if (s1_move) begin
      burst_rem <= writes.n;
    end else if (out_take) begin
      burst_rem <= burst_rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      burst <= writes.ent;
    end else if (out_take) begin
      burst[0] <= burst[1];
      burst[1] <= burst[2];
    end
  end

`ifndef SYNTH
  // A request waits in the input register only while the burst register is busy.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (burst_rem != 2'd0) && !(burst_rem == 2'd1 && out_take))
    else $error("input stalled although burst register is free");

  // Writes of one request never report a falling byte count.
  assert property (@(posedge clk) disable iff (rst)
    out_take && !last |=> out_valid && (bytes_written >= $past(bytes_written)))
    else $error("byte count fell within one request");

  // After the final write of a request, further writes come only from a new load.
  assert property (@(posedge clk) disable iff (rst)
    out_take && last |=> !out_valid || $past(s1_move))
    else $error("writes shown after last without a new request");

  // A load never exceeds three writes and always carries at least one for a
  // valid request code.
  assert property (@(posedge clk) disable iff (rst)
    s1_move && (s1_req == cre_pkg::REQ_BEGIN || s1_req == cre_pkg::REQ_DATA ||
                s1_req == cre_pkg::REQ_FINISH) |-> writes.n != 2'd0)
    else $error("request produced no writes");
`endif

endmodule

FILE: src/cre_step.sv
module cre_step (
  input  logic [1:0]                 req,
  input  logic [7:0]                 data_byte,
  input  logic [cre_pkg::POS_W-1:0]  start_position,
  input  logic [cre_pkg::SIZE_W-1:0] size_use,
  input  cre_pkg::enc_state_t        cur,
  output cre_pkg::enc_state_t        nxt,
  output cre_pkg::writes_t           res
);

  function automatic logic [cre_pkg::POS_W-1:0] next_pos(
    input logic [cre_pkg::POS_W-1:0]  p,
    input logic [cre_pkg::SIZE_W-1:0] s
  );
    logic [cre_pkg::SIZE_W-1:0] n;
    n = {1'b0, p} + cre_pkg::SIZE_W'(1);
    return (n >= s) ? '0 : n[cre_pkg::POS_W-1:0];
  endfunction

  function automatic logic [cre_pkg::CNT_W-1:0] sat_inc(
    input logic [cre_pkg::CNT_W-1:0] c
  );
    return (c == cre_pkg::CNT_MAX) ? c : c + cre_pkg::CNT_W'(1);
  endfunction

  logic [cre_pkg::POS_W-1:0] start_eff;
  logic [cre_pkg::POS_W-1:0] wp1;
  logic [cre_pkg::POS_W-1:0] wp2;
  logic [cre_pkg::CNT_W-1:0] fc1;
  logic [cre_pkg::CNT_W-1:0] fc2;
  logic [7:0]                rc1;

  always_comb begin
    start_eff = ({1'b0, start_position} >= size_use) ? '0 : start_position;
    wp1 = next_pos(cur.write_pos, size_use);
    wp2 = next_pos(wp1, size_use);
    fc1 = sat_inc(cur.frame_count);
    fc2 = sat_inc(fc1);
    rc1 = cur.run_code + 8'd1;

    nxt = cur;
    res = '0;
    case (req)
      cre_pkg::REQ_BEGIN: begin
        res.n = 2'd1;
        res.ent[0] = '{addr: start_eff, data: 8'd0, count: cre_pkg::CNT_W'(1)};
        nxt.code_slot   = start_eff;
        nxt.frame_count = cre_pkg::CNT_W'(1);
        nxt.write_pos   = next_pos(start_eff, size_use);
        nxt.run_code    = 8'd1;
      end
      cre_pkg::REQ_DATA: begin
        if (data_byte == 8'd0) begin
          // A zero byte closes the block: patch its code, reserve a new slot.
          res.n = 2'd2;
          res.ent[0] = '{addr: cur.code_slot, data: cur.run_code, count: cur.frame_count};
          res.ent[1] = '{addr: cur.write_pos, data: 8'd0, count: fc1};
          nxt.code_slot   = cur.write_pos;
          nxt.write_pos   = wp1;
          nxt.run_code    = 8'd1;
          nxt.frame_count = fc1;
        end else begin
          res.n = 2'd1;
          res.ent[0] = '{addr: cur.write_pos, data: data_byte, count: fc1};
          nxt.write_pos   = wp1;
          nxt.run_code    = rc1;
          nxt.frame_count = fc1;
          if (rc1 == cre_pkg::CODE_MAX) begin
            // Full block: close it right away.
            res.n = 2'd3;
            res.ent[1] = '{addr: cur.code_slot, data: cre_pkg::CODE_MAX, count: fc1};
            res.ent[2] = '{addr: wp1, data: 8'd0, count: fc2};
            nxt.code_slot   = wp1;
            nxt.write_pos   = wp2;
            nxt.run_code    = 8'd1;
            nxt.frame_count = fc2;
          end
        end
      end
      cre_pkg::REQ_FINISH: begin
        res.n = 2'd2;
        res.ent[0] = '{addr: cur.code_slot, data: cur.run_code, count: cur.frame_count};
        res.ent[1] = '{addr: cur.write_pos, data: 8'd0, count: fc1};
        nxt.write_pos   = wp1;
        nxt.frame_count = fc1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
